// File: design/mlpq_pkg.sv
package mlpq_pkg;

	localparam int NUM_LEVELS  = 8;
	localparam int MAX_THREADS = 64;
	localparam int LEVEL_W     = $clog2(NUM_LEVELS);
	localparam int THREAD_W    = $clog2(MAX_THREADS);

	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_SCHEDULE = 2'd1,
		CMD_EVICT    = 2'd2,
		CMD_PREEMPT  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LINK = 2'b10
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;       // request taken this cycle
		logic link_commit;  // load the popped level's head from the link read
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_link;    // incoming schedule pops a head that has a successor
	} dp_stat_t;

endpackage

// File: design/mlpq_ctrl.sv
module mlpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mlpq_pkg::dp_stat_t stat,
	output mlpq_pkg::dp_cmd_t  cmd,
	output logic               busy
);
	import mlpq_pkg::*;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign busy      = (state_q == ST_LINK);

	assign cmd.accept      = accept;
	assign cmd.link_commit = (state_q == ST_LINK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && stat.need_link)
						state_q <= ST_LINK;
				end
				ST_LINK: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (accept)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: design/mlpq_dp.sv
module mlpq_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mlpq_pkg::dp_cmd_t               cmd,
	output mlpq_pkg::dp_stat_t              stat,
	input  logic [1:0]                      command,
	input  logic [mlpq_pkg::THREAD_W-1:0]   thread_id,
	input  logic [mlpq_pkg::LEVEL_W-1:0]    priority_req,
	output logic [mlpq_pkg::THREAD_W-1:0]   result_thread,
	output logic                            result_valid,
	output logic                            status
);
	import mlpq_pkg::*;

	// queue state
	logic [THREAD_W-1:0] head_q [NUM_LEVELS];
	logic [THREAD_W-1:0] tail_q [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] nonempty_q;
	logic [THREAD_W-1:0] link_q [MAX_THREADS];
	logic [THREAD_W-1:0] link_rd_q;
	logic [LEVEL_W-1:0]  pop_lvl_q;

	// running thread
	logic [THREAD_W-1:0] run_thread_q;
	logic                run_valid_q;
	logic [LEVEL_W-1:0]  run_pri_q;

	// result register
	logic [THREAD_W-1:0] res_thread_q;
	logic                res_valid_q;
	logic                res_status_q;

	cmd_t                cmd_in;
	logic                found;
	logic [LEVEL_W-1:0]  sched_lvl;
	logic [THREAD_W-1:0] sched_head;
	logic                sched_last;
	logic                is_add;
	logic                is_sched;
	logic                is_take;
	logic                enq_en;
	logic [THREAD_W-1:0] enq_tid;
	logic [LEVEL_W-1:0]  enq_lvl;
	logic                enq_append;

	assign cmd_in   = cmd_t'(command);
	assign is_add   = (cmd_in == CMD_ADD);
	assign is_sched = (cmd_in == CMD_SCHEDULE);
	assign is_take  = (cmd_in == CMD_EVICT) || (cmd_in == CMD_PREEMPT);

	// lowest-numbered nonempty level wins
	always_comb begin
		found     = 1'b0;
		sched_lvl = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				found     = 1'b1;
				sched_lvl = LEVEL_W'(i);
			end
		end
	end

	assign sched_head = head_q[sched_lvl];
	assign sched_last = (sched_head == tail_q[sched_lvl]);

	// add enqueues the request's thread; preempt re-queues the running one
	assign enq_en     = cmd.accept &&
		(is_add || ((cmd_in == CMD_PREEMPT) && run_valid_q));
	assign enq_tid    = is_add ? thread_id : run_thread_q;
	assign enq_lvl    = is_add ? priority_req : run_pri_q;
	assign enq_append = nonempty_q[enq_lvl];

	assign stat.need_link = is_sched && found && !sched_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q   <= '0;
			run_thread_q <= '0;
			run_valid_q  <= 1'b0;
			run_pri_q    <= '0;
		end else if (cmd.accept) begin
			if (enq_en && !enq_append)
				nonempty_q[enq_lvl] <= 1'b1;
			if (is_sched && found) begin
				if (sched_last)
					nonempty_q[sched_lvl] <= 1'b0;
				run_thread_q <= sched_head;
				run_valid_q  <= 1'b1;
				run_pri_q    <= sched_lvl;
			end
			if (is_take)
				run_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (enq_en) begin
			if (!enq_append)
				head_q[enq_lvl] <= enq_tid;
			tail_q[enq_lvl] <= enq_tid;
		end
		if (cmd.link_commit)
			head_q[pop_lvl_q] <= link_rd_q;
	end

	// link memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (enq_en && enq_append)
			link_q[tail_q[enq_lvl]] <= enq_tid;
		if (cmd.accept && stat.need_link) begin
			link_rd_q <= link_q[sched_head];
			pop_lvl_q <= sched_lvl;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			unique case (cmd_in)
				CMD_ADD: begin
					res_thread_q <= '0;
					res_valid_q  <= 1'b0;
					res_status_q <= 1'b0;
				end
				CMD_SCHEDULE: begin
					res_thread_q <= found ? sched_head : '0;
					res_valid_q  <= found;
					res_status_q <= !found;
				end
				CMD_EVICT, CMD_PREEMPT: begin
					res_thread_q <= run_valid_q ? run_thread_q : '0;
					res_valid_q  <= run_valid_q;
					res_status_q <= 1'b0;
				end
				default: begin
					res_thread_q <= '0;
					res_valid_q  <= 1'b0;
					res_status_q <= 1'b0;
				end
			endcase
		end
	end

	assign result_thread = res_thread_q;
	assign result_valid  = res_valid_q;
	assign status        = res_status_q;

endmodule

// File: design/multilevel_priority_fifo_scheduler.sv
// Thread scheduler with one FIFO ready queue per priority level (level 0 is
// served first), kept as linked lists in a 64-entry link memory. Each request
// on s_axis gives exactly one result on m_axis. Add, evict, preempt, a schedule
// that finds every level empty and a schedule that takes the last thread of a
// level stay in the idle state; a schedule that leaves threads in its level
// also passes through the link state, taking no request there, since the new
// head comes from the registered read port of the link memory. A finished
// result sits in an output register; outside the link state the next request
// can be taken in the same cycle that the result is taken. Reset clears the
// level flags and the running thread; heads, tails and links are only defined once written.
module multilevel_priority_fifo_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // command[1:0], thread_id[7:2], priority_req[10:8]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // result_thread[5:0], result_valid[6], status[7]
);
	import mlpq_pkg::*;

	dp_cmd_t             cmd;
	dp_stat_t            stat;
	logic                busy;
	logic [THREAD_W-1:0] result_thread;
	logic                result_valid;
	logic                status;

	mlpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	mlpq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.command       (s_axis_tdata[1:0]),
		.thread_id     (s_axis_tdata[7:2]),
		.priority_req  (s_axis_tdata[10:8]),
		.result_thread (result_thread),
		.result_valid  (result_valid),
		.status        (status)
	);

	assign m_axis_tdata = {status, result_valid, result_thread};

`ifndef ASSERT_OFF
	a_link_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("link update state lasted more than one cycle");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready)
		else $error("request taken during link update");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> !(m_axis_tvalid && !m_axis_tready))
		else $error("request taken while a result is stalled");

	a_status_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[7] && m_axis_tdata[6]))
		else $error("empty status reported with a valid thread");
`endif

endmodule
